FILE: sv/dsw_pkg.sv
// Shared types and state codes for the debounced two-switch door tracker.
`default_nettype none
package dsw_pkg;

	localparam int DEBOUNCE_W = 16;
	localparam int TIME_W = 32;
	localparam int STATE_W = 3;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

	localparam logic [STATE_W-1:0] ST_UNKNOWN = 3'd0;
	localparam logic [STATE_W-1:0] ST_OPEN = 3'd1;
	localparam logic [STATE_W-1:0] ST_CLOSED = 3'd2;
	localparam logic [STATE_W-1:0] ST_OPENING = 3'd3;
	localparam logic [STATE_W-1:0] ST_CLOSING = 3'd4;
	localparam logic [STATE_W-1:0] ST_ERROR = 3'd5;

	typedef struct packed {
		logic last;
		logic stable;
		logic [TIME_W-1:0] change_time;
	} sw_state_t;

endpackage
`default_nettype wire

FILE: sv/dsw_debounce.sv
// Next-state logic of one debounced switch.
`default_nettype none
module dsw_debounce (
	input  wire logic                           primed,
	input  wire logic                           reading,
	input  wire logic [dsw_pkg::TIME_W-1:0]     now_ms,
	input  wire logic [dsw_pkg::DEBOUNCE_W-1:0] debounce_ms,
	input  wire dsw_pkg::sw_state_t             cur,
	output dsw_pkg::sw_state_t                  nxt
);
	import dsw_pkg::*;

	logic                last_eff;
	logic                stable_eff;
	logic [TIME_W-1:0]   change_time;
	logic [TIME_W-1:0]   elapsed;

	always_comb begin
		// first sample primes last and stable with the reading
		last_eff = primed ? cur.last : reading;
		stable_eff = primed ? cur.stable : reading;
		change_time = (reading != last_eff) ? now_ms : cur.change_time;
		elapsed = now_ms - change_time;
		nxt.last = reading;
		nxt.change_time = change_time;
		nxt.stable = (elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms}) ?
			reading : stable_eff;
	end

endmodule
`default_nettype wire

FILE: sv/dsw_door_fsm.sv
// Next-state logic of the door position state machine.
`default_nettype none
module dsw_door_fsm (
	input  wire logic                        top_stable,
	input  wire logic                        bottom_stable,
	input  wire logic [dsw_pkg::STATE_W-1:0] cur_state,
	output logic      [dsw_pkg::STATE_W-1:0] nxt_state
);
	import dsw_pkg::*;

	always_comb begin
		case ({top_stable, bottom_stable})
			2'b10: nxt_state = ST_OPEN;
			2'b01: nxt_state = ST_CLOSED;
			2'b11: nxt_state = ST_ERROR;
			default: begin
				case (cur_state)
					ST_CLOSED: nxt_state = ST_OPENING;
					ST_OPEN:   nxt_state = ST_CLOSING;
					default:   nxt_state = cur_state;
				endcase
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/debounced_two_switch_door_state_top.sv
// Top level: sample register, debounce and door state update, result register.
// A sample passes the sample register, then its result is held in the result register.
// Throughput: one sample per cycle, set by the state update loop, while no result is stalled.
// A sample that leaves the state unchanged gives no output transaction.
// Reset (arst_n low, asynchronous) clears the pipeline, the switch and door
// state, and sets debounce_ms to 50.
`default_nettype none
module debounced_two_switch_door_state_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,      // debounce_ms
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,       // top_level, bottom_level, now_ms, zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata        // door_state, zero pad
);
	import dsw_pkg::*;

	logic                  valid_s1;
	logic                  top_s1;
	logic                  bottom_s1;
	logic [TIME_W-1:0]     now_s1;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic                  primed_q;
	sw_state_t             top_q, bottom_q, top_nxt, bottom_nxt;
	logic [STATE_W-1:0]    door_q, door_nxt;

	logic                  out_valid_q;
	logic [STATE_W-1:0]    out_state_q;
	logic                  advance;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			top_s1 <= s_tdata[0];
			bottom_s1 <= s_tdata[1];
			now_s1 <= s_tdata[33:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_data;
		end
	end

	dsw_debounce u_top_db (
		.primed      (primed_q),
		.reading     (top_s1),
		.now_ms      (now_s1),
		.debounce_ms (debounce_q),
		.cur         (top_q),
		.nxt         (top_nxt)
	);

	dsw_debounce u_bottom_db (
		.primed      (primed_q),
		.reading     (bottom_s1),
		.now_ms      (now_s1),
		.debounce_ms (debounce_q),
		.cur         (bottom_q),
		.nxt         (bottom_nxt)
	);

	dsw_door_fsm u_fsm (
		.top_stable    (top_nxt.stable),
		.bottom_stable (bottom_nxt.stable),
		.cur_state     (door_q),
		.nxt_state     (door_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			top_q <= '0;
			bottom_q <= '0;
			door_q <= ST_UNKNOWN;
		end else if (advance) begin
			primed_q <= 1'b1;
			top_q <= top_nxt;
			bottom_q <= bottom_nxt;
			door_q <= door_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= (door_nxt != door_q);
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q <= door_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(8-STATE_W){1'b0}}, out_state_q};

endmodule
`default_nettype wire
